// ----- src/nnt_pkg.sv -----
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types and constants for the nearest-neighbour tour builder.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_CITIES_DEF = 32;
  localparam int DIST_BITS_DEF  = 16;

  localparam int CFG_W  = 6;
  localparam int COST_W = 21;

  localparam logic [CFG_W-1:0]  CFG_RESET = 6'd29;
  localparam logic [COST_W-1:0] COST_MAX  = '1;

  // kind of an input beat, carried on s_tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_BUILD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_EMIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_STEP,
    ST_CLOSE_RD,
    ST_CLOSE_ADD,
    ST_LAST
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan_rd;
    logic step;
    logic close_rd;
    logic close_add;
    logic emit_pos;
    logic emit_last;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic bad_start;
    logic scan_last;
    logic at_last;
    logic slot_free;
  } status_t;

endpackage

// ----- src/nnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnt_ctrl
// Sequencer for loads and tour builds: scan, step, close and result beats.
// ----------------------------------------------------------------------------
module nnt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_ready,
  input  nnt_pkg::status_t sts,
  output nnt_pkg::cmd_t    cmd
);
  import nnt_pkg::*;

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == ACT_LOAD) begin
            cmd.load = 1'b1;
          end else if (sts.bad_start) begin
            state_next = ST_ERR;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_EMIT;
          end
        end
      end
      ST_ERR: begin
        if (sts.slot_free) begin
          cmd.emit_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // final city waits for the closing leg before its beat goes out
        if (sts.at_last) begin
          state_next = ST_CLOSE_RD;
        end else if (sts.slot_free) begin
          cmd.emit_pos = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_CLOSE_RD: begin
        cmd.close_rd = 1'b1;
        state_next   = ST_CLOSE_ADD;
      end
      ST_CLOSE_ADD: begin
        cmd.close_add = 1'b1;
        state_next    = ST_LAST;
      end
      ST_LAST: begin
        if (sts.slot_free) begin
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pos || cmd.emit_last || cmd.emit_err) |-> sts.slot_free)
    else $error("result beat loaded while output register still full");

  a_step_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |=> (state == ST_EMIT))
    else $error("step not followed by emit");

  a_close_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSE_RD) |=> (state == ST_CLOSE_ADD) ##1 (state == ST_LAST))
    else $error("closing leg sequence broken");

endmodule

// ----- src/nnt_dpath.sv -----
// ----------------------------------------------------------------------------
// nnt_dpath
// Distance memory, nearest-city compare, running cost and output register.
// ----------------------------------------------------------------------------
module nnt_dpath #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = nnt_pkg::DIST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              in_data,
  input  logic                     cfg_we,
  input  logic [nnt_pkg::CFG_W-1:0] cfg_data,
  input  nnt_pkg::cmd_t            cmd,
  output nnt_pkg::status_t         sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [31:0]              out_data,
  output logic                     out_user,
  output logic                     out_last
);
  import nnt_pkg::*;

  localparam int CW  = $clog2(MAX_CITIES);
  localparam int AW  = 2 * CW;
  localparam int LIM = (MAX_CITIES < 32) ? MAX_CITIES : 32;
  localparam int SW  = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;

  logic [DIST_BITS-1:0] mem [2**AW];

  logic [CFG_W-1:0]     cities_cfg;
  logic [CFG_W-1:0]     n_eff;
  logic [CW-1:0]        nm1;

  logic [4:0]           ld_from, ld_to, ld_start;
  logic [15:0]          ld_dist;
  logic                 ld_in_range;

  logic [MAX_CITIES-1:0] visited;
  logic [CW-1:0]        cur, start_r, k, cnt, cnt_d, best;
  logic                 cmp_en, found;
  logic [DIST_BITS-1:0] bestd, rd_data;
  logic [AW-1:0]        rd_addr;
  logic [COST_W-1:0]    cost, cost_next;
  logic [DIST_BITS-1:0] addend;
  logic [SW-1:0]        sum;

  assign ld_from  = in_data[4:0];
  assign ld_to    = in_data[9:5];
  assign ld_dist  = in_data[25:10];
  assign ld_start = in_data[30:26];

  always_ff @(posedge clk) begin
    if (rst) begin
      cities_cfg <= CFG_RESET;
    end else if (cfg_we) begin
      cities_cfg <= cfg_data;
    end
  end

  assign n_eff = (cities_cfg > CFG_W'(LIM)) ? CFG_W'(LIM) : cities_cfg;
  assign nm1   = CW'(n_eff - CFG_W'(1));

  // memory: one write port for loads, one registered read port for builds
  assign ld_in_range = (32'(ld_from) < MAX_CITIES) && (32'(ld_to) < MAX_CITIES);
  assign rd_addr     = cmd.close_rd ? {cur, start_r} : {cur, cnt};

  always_ff @(posedge clk) begin
    if (cmd.load && ld_in_range) begin
      mem[{CW'(ld_from), CW'(ld_to)}] <= DIST_BITS'(ld_dist);
    end
    rd_data <= mem[rd_addr];
  end

  // saturating cost add, shared by the step and the closing leg
  assign addend    = cmd.close_add ? rd_data : bestd;
  assign sum       = SW'(cost) + SW'(addend);
  assign cost_next = (sum > SW'(COST_MAX)) ? COST_MAX : COST_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en  <= 1'b0;
      found   <= 1'b0;
      visited <= '0;
      cur     <= '0;
      k       <= '0;
      cnt     <= '0;
      cost    <= '0;
    end else begin
      cmp_en <= cmd.scan_rd;
      cnt_d  <= cnt;
      if (cmd.scan_rd) begin
        cnt <= cnt + CW'(1);
      end
      // compare the beat read in the previous cycle
      if (cmp_en && !visited[cnt_d] && (!found || rd_data < bestd)) begin
        found <= 1'b1;
        bestd <= rd_data;
        best  <= cnt_d;
      end
      if (cmd.start) begin
        start_r <= CW'(ld_start);
        cur     <= CW'(ld_start);
        visited <= MAX_CITIES'(1) << CW'(ld_start);
        k       <= '0;
        cnt     <= '0;
        found   <= 1'b0;
        cost    <= '0;
      end
      if (cmd.step) begin
        cost    <= cost_next;
        visited <= visited | (MAX_CITIES'(1) << best);
        cur     <= best;
        k       <= k + CW'(1);
        cnt     <= '0;
        found   <= 1'b0;
      end
      if (cmd.close_add) begin
        cost <= cost_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_pos || cmd.emit_last || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_data <= '0;
      out_user <= 1'b1;
      out_last <= 1'b1;
    end else if (cmd.emit_pos || cmd.emit_last) begin
      out_data <= {1'b0, (cmd.emit_last ? cost : COST_W'(0)), 5'(cur), 5'(k)};
      out_user <= 1'b0;
      out_last <= cmd.emit_last;
    end
  end

  assign sts.bad_start = ({1'b0, ld_start} >= n_eff);
  assign sts.scan_last = (cnt == nm1);
  assign sts.at_last   = (k == nm1);
  assign sts.slot_free = !out_valid || out_ready;

  a_step_found: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> found)
    else $error("step taken without a candidate city");

  a_step_new: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> ($countones(visited) == $past($countones(visited)) + 1))
    else $error("step chose an already visited city");

endmodule

// ----- src/nearest_neighbour_tour_builder.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_builder
// Greedy closed-tour builder over a loaded distance matrix.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata: from, to, distance, start; tuser: action
// m_*      out  tvalid/tready      tdata: position, city, tour_cost; tuser: bad_start
// cfg_*    in   cfg_we             cfg_data: cities_in_use
//
// Loads are accepted while idle, and the input stays ready for the next one.
// The length of a build of n cities is set by the single read port of the
// distance memory: each step scans all n entries of the current row, one read per cycle.
// Reset (rst, synchronous) clears the control state and sets cities_in_use
// to 29; the distance memory has no reset. A stalled output holds the
// sequencer at the next result beat.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_builder #(
  parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = nnt_pkg::DIST_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,  // from_city, to_city, distance, start_city
  input  logic                      s_tuser,  // action
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,  // position, city, tour_cost
  output logic                      m_tuser,  // bad_start
  output logic                      m_tlast,
  input  logic                      cfg_we,
  input  logic [nnt_pkg::CFG_W-1:0] cfg_data
);
  import nnt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  nnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nnt_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

// ----- tb/sv/nearest_neighbour_tour_builder_tb.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_builder_tb
// Self-checking bench for the greedy tour builder. Load and build beats go
// in from a directed table, then from random phases at several city counts.
// An in-bench predictor keeps its own copy of the distance matrix and works
// out every tour. Each output beat is checked against the oldest expected
// beat. Both sides idle at random, and the output side holds off once for a
// long stretch so that the input side stalls.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_builder_tb;
  import nnt_pkg::*;

  localparam int NCITY      = MAX_CITIES_DEF;
  localparam int WATCHDOG   = 6000;
  localparam int HOLD_OFF   = 400;
  localparam int PHASE_LEN  = 24;
  localparam int DRAIN_WAIT = 40;
  localparam int IDLE_WAIT  = 16;

  typedef struct packed {
    logic [4:0]        position;
    logic [4:0]        city;
    logic [COST_W-1:0] tour_cost;
    logic              bad_start;
    logic              last;
  } tour_beat_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_BUILD} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        a;         // cfg value, from city or start city
    int        b;         // to city
    int        d;         // distance
    bit        typed_err; // expect the single bad-start beat
  } stim_row_t;

  localparam tour_beat_t BAD_START_BEAT = '{position: '0, city: '0, tour_cost: '0,
                                            bad_start: 1'b1, last: 1'b1};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;
  logic             s_tuser = ACT_LOAD;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [DIST_BITS_DEF-1:0] dist_copy [NCITY][NCITY];
  bit                       entry_loaded [NCITY][NCITY];
  logic [CFG_W-1:0]         tour_cities = CFG_RESET;
  tour_beat_t               tour_expect [$];

  int  error_count = 0;
  int  beats_seen = 0;
  int  quiet_cycles = 0;
  bit  sender_quiet = 1'b0;
  bit  hold_off_pending = 1'b0;
  bit  hold_off_used = 1'b0;

  stim_row_t directed_rows [] = '{
    '{ROW_BUILD, 29, 0, 0, 1'b1},   // start equal to the reset city count
    '{ROW_BUILD, 31, 0, 0, 1'b1},
    '{ROW_CFG,    2, 0, 0, 1'b0},
    '{ROW_LOAD,   0, 1, 65535, 1'b0},
    '{ROW_LOAD,   1, 0, 65535, 1'b0},
    '{ROW_BUILD,  0, 0, 0, 1'b0},
    '{ROW_BUILD,  1, 0, 0, 1'b0},
    '{ROW_BUILD,  2, 0, 0, 1'b1},
    '{ROW_CFG,    3, 0, 0, 1'b0},
    '{ROW_LOAD,   0, 1, 5, 1'b0},
    '{ROW_LOAD,   0, 2, 5, 1'b0},   // tie with city 1: lower number wins
    '{ROW_LOAD,   1, 2, 0, 1'b0},
    '{ROW_LOAD,   2, 0, 0, 1'b0},
    '{ROW_LOAD,   2, 1, 0, 1'b0},
    '{ROW_BUILD,  0, 0, 0, 1'b0},
    '{ROW_BUILD,  2, 0, 0, 1'b0},
    '{ROW_CFG,    1, 0, 0, 1'b0},
    '{ROW_BUILD,  0, 0, 0, 1'b0},   // one-city tour costs the self distance
    '{ROW_LOAD,   0, 0, 65535, 1'b0},
    '{ROW_BUILD,  0, 0, 0, 1'b0},
    '{ROW_BUILD,  1, 0, 0, 1'b1},
    '{ROW_CFG,    0, 0, 0, 1'b0},
    '{ROW_BUILD,  0, 0, 0, 1'b1}    // zero cities: every start is bad
  };

  int city_plan [] = '{5, 2, 8, 0, 3, 4, 12, 1, 7, 6};

  nearest_neighbour_tour_builder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int cities_used();
    return (tour_cities > NCITY) ? NCITY : int'(tour_cities);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3);
    if (r < 70) return $urandom_range(0, 255);
    if (r < 90) return $urandom_range(0, 65535);
    if (r < 95) return 65535;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Greedy walk over the matrix copy; ties go to the lowest city.
  function automatic void predict_tour(input logic [4:0] start);
    int           n;
    int           cur;
    int           best;
    int unsigned  bestd;
    int unsigned  cost;
    bit           found;
    bit [NCITY-1:0] seen;
    tour_beat_t   beat;
    tour_beat_t   walk [$];
    n = cities_used();
    if (start >= n) begin
      tour_expect.push_back(BAD_START_BEAT);
      return;
    end
    seen = '0;
    seen[start] = 1'b1;
    cur = start;
    cost = 0;
    beat = '{position: '0, city: start, tour_cost: '0, bad_start: 1'b0, last: 1'b0};
    walk.push_back(beat);
    for (int k = 1; k < n; k++) begin
      found = 1'b0;
      best = 0;
      bestd = 0;
      for (int c = 0; c < n; c++) begin
        if (!seen[c] && (!found || dist_copy[cur][c] < bestd)) begin
          found = 1'b1;
          bestd = dist_copy[cur][c];
          best = c;
        end
      end
      cost = (cost + bestd > COST_MAX) ? COST_MAX : cost + bestd;
      seen[best] = 1'b1;
      cur = best;
      beat.position = 5'(k);
      beat.city = 5'(best);
      walk.push_back(beat);
    end
    cost = (cost + dist_copy[cur][start] > COST_MAX) ? COST_MAX
                                                     : cost + dist_copy[cur][start];
    walk[walk.size()-1].tour_cost = COST_W'(cost);
    walk[walk.size()-1].last = 1'b1;
    foreach (walk[i]) tour_expect.push_back(walk[i]);
  endfunction

  task automatic send_beat(input logic act, input int from, input int to,
                           input int dist_val, input int start);
    int gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, 5'(start), 16'(dist_val), 5'(to), 5'(from)};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load_entry(input int from, input int to, input int dist_val);
    send_beat(ACT_LOAD, from, to, dist_val, $urandom_range(0, 31));
    dist_copy[from][to] = DIST_BITS_DEF'(dist_val);
    entry_loaded[from][to] = 1'b1;
  endtask

  // Load every entry a tour over the cities in use can read.
  task automatic fill_matrix(input int n);
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        if (!entry_loaded[a][b]) load_entry(a, b, pick_distance());
  endtask

  task automatic build_tour(input int start, input bit typed_err);
    if (start < cities_used()) fill_matrix(cities_used());
    send_beat(ACT_BUILD, $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 65535), start);
    if (typed_err) tour_expect.push_back(BAD_START_BEAT);
    else predict_tour(5'(start));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tour_expect.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_cities(input int value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    tour_cities = CFG_W'(value);
  endtask

  task automatic random_item();
    int n;
    int pct;
    int a;
    int b;
    n = cities_used();
    pct = (n <= 8) ? 45 : 12;
    if ($urandom_range(0, 99) < pct) begin
      if (n == 0 || $urandom_range(0, 4) == 0) build_tour($urandom_range(0, 31), 1'b0);
      else build_tour($urandom_range(0, n - 1), 1'b0);
    end else begin
      if (n > 0 && $urandom_range(0, 9) < 7) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end else begin
        a = $urandom_range(0, 31);
        b = $urandom_range(0, 31);
      end
      load_entry(a, b, pick_distance());
    end
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG:   write_cities(directed_rows[i].a);
        ROW_LOAD:  load_entry(directed_rows[i].a, directed_rows[i].b, directed_rows[i].d);
        ROW_BUILD: build_tour(directed_rows[i].a, directed_rows[i].typed_err);
        default: ;
      endcase
    end
    foreach (city_plan[p]) begin
      write_cities(city_plan[p]);
      sender_quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_LEN) random_item();
    end
    s_tvalid <= 1'b0;
    while (tour_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side: random ready pattern, one long hold-off mid-build
  initial begin
    int burst;
    int gap;
    @(negedge rst);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      m_tready <= 1'b1;
      for (int i = 0; i < burst && !hold_off_pending; i++) @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    tour_beat_t want;
    tour_beat_t got;
    if (m_tvalid && m_tready) begin
      got = '{position: m_tdata[4:0], city: m_tdata[9:5], tour_cost: m_tdata[30:10],
              bad_start: m_tuser, last: m_tlast};
      beats_seen++;
      if (tour_expect.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: pos %0d city %0d",
                                  got.position, got.city));
      end else begin
        want = tour_expect.pop_front();
        if (got.position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
        if (got.city !== want.city)
          report_mismatch($sformatf("city %0d, want %0d", got.city, want.city));
        if (got.tour_cost !== want.tour_cost)
          report_mismatch($sformatf("tour_cost %0d, want %0d", got.tour_cost,
                                    want.tour_cost));
        if (got.bad_start !== want.bad_start)
          report_mismatch($sformatf("bad_start %b, want %b", got.bad_start, want.bad_start));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
      // stall the output mid-tour once so the input backs up
      if (!hold_off_used && beats_seen >= 60 && !m_tlast) begin
        hold_off_used = 1'b1;
        hold_off_pending = 1'b1;
      end
    end
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
src/nnt_pkg.sv
src/nnt_ctrl.sv
src/nnt_dpath.sv
src/nearest_neighbour_tour_builder.sv
tb/sv/nearest_neighbour_tour_builder_tb.sv
